// ----- hdl/board_timer_and_serial_tx_io_top_defines.svh -----
// Assertion macros shared by the board timer and serial transmit block.
// Depends on nothing; the checker file includes it.
`ifndef BOARD_TIMER_AND_SERIAL_TX_IO_TOP_DEFINES_SVH
`define BOARD_TIMER_AND_SERIAL_TX_IO_TOP_DEFINES_SVH

// Check a property on clk_i, skipped while rst_ni is low.
`define BTSTX_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("btstx: property failed");

// Check a property on clk_i, also while reset is applied.
`define BTSTX_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("btstx: property failed during reset");

`endif

// ----- hdl/btstx_pkg.sv -----
// Types and constants of the board timer and serial transmit block.
// Used by the top level and by its checker; depends on nothing.
package btstx_pkg;

  localparam int unsigned ActionW  = 2;
  localparam int unsigned AddrW    = 24;
  localparam int unsigned WdataW   = 16;
  localparam int unsigned CyclesW  = 8;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned IrqW     = 3;
  localparam int unsigned CountW   = 24;
  localparam int unsigned PreW     = 10;

  // Item kinds; code 3 has no effect
  typedef enum logic [ActionW-1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2
  } action_e;

  // Device register addresses
  localparam logic [AddrW-1:0] ADDR_SER_CTRL = 24'h0C0080;
  localparam logic [AddrW-1:0] ADDR_SER_DATA = 24'h0C0082;
  localparam logic [AddrW-1:0] ADDR_RLD_H    = 24'h0E0027;
  localparam logic [AddrW-1:0] ADDR_RLD_M    = 24'h0E0029;
  localparam logic [AddrW-1:0] ADDR_RLD_L    = 24'h0E002B;
  localparam logic [AddrW-1:0] ADDR_TCTRL    = 24'h0E0021;
  localparam logic [AddrW-1:0] ADDR_TSTAT    = 24'h0E0035;

  localparam logic [ByteW-1:0] SER_ENABLE_KEY  = 8'h95;
  localparam logic [ByteW-1:0] SER_STATUS_RD   = 8'h02;
  localparam logic [ByteW-1:0] TSTAT_CLEAR_KEY = 8'h01;
  localparam int unsigned      TCTRL_EN_BIT    = 5;
  localparam logic [IrqW-1:0]  IRQ_TIMER       = 3'd5;
  localparam logic [IrqW-1:0]  IRQ_NONE        = 3'd0;

endpackage

// ----- hdl/board_timer_and_serial_tx_io_top.sv -----
// Board I/O block: down-counting timer with prescaler and a transmit-only serial port.
// Depends on btstx_pkg.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------------------
//   in      | sink      | in_valid_i / in_stall_o | action, bus_address, word_access, ...
//   out     | source    | out_valid_o/out_stall_i | read_data, handled_here, ..., timer_on
//
// One item per cycle while the output is not stalled: an input register, then the
// timer and register decode in one pass into the result register.
// Reset clears the timer, reload value, enables and interrupt level.
// A stalled result holds; the input register keeps taking a beat until it
// is full and the result register cannot drain.
module board_timer_and_serial_tx_io_top #(
  parameter int unsigned PRESCALE_DIV = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [btstx_pkg::ActionW-1:0]         action_i,
  input  logic [btstx_pkg::AddrW-1:0]           bus_address_i,
  input  logic                                  word_access_i,
  input  logic [btstx_pkg::WdataW-1:0]          write_value_i,
  input  logic [btstx_pkg::CyclesW-1:0]         elapsed_cycles_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [btstx_pkg::ByteW-1:0]           read_data_o,
  output logic                                  handled_here_o,
  output logic                                  access_fault_o,
  output logic                                  tx_valid_o,
  output logic [btstx_pkg::ByteW-1:0]           tx_byte_o,
  output logic [btstx_pkg::IrqW-1:0]            irq_level_o,
  output logic                                  serial_on_o,
  output logic                                  timer_on_o
);
  import btstx_pkg::*;

  localparam logic signed [PreW-1:0] PreDiv = PreW'(PRESCALE_DIV);

  // Input register
  logic               in_vld_q;
  logic [ActionW-1:0] action_q;
  logic [AddrW-1:0]   addr_q;
  logic               word_q;
  logic [ByteW-1:0]   wbyte_q;
  logic [CyclesW-1:0] cycles_q;

  // Block state
  logic [CountW-1:0]      cnt_q, cnt_d;
  logic [CountW-1:0]      rld_q, rld_d;
  logic signed [PreW-1:0] pre_q, pre_d;
  logic                   ten_q, ten_d;
  logic                   sen_q, sen_d;
  logic [IrqW-1:0]        irq_q, irq_d;

  // Result register
  logic             out_vld_q;
  logic [ByteW-1:0] rdata_q, rdata_d;
  logic             hit_q, hit_d;
  logic             fault_q, fault_d;
  logic             txv_q, txv_d;
  logic [ByteW-1:0] txb_q, txb_d;

  logic out_free, fire, in_take;
  logic is_dev;
  logic signed [PreW-1:0] pre_sub;
  logic                   pre_neg;
  logic [CountW-1:0]      cnt_dec;

  // Handshake: the result register drains or is empty, then the stage advances
  assign out_free   = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // Hold the accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      action_q <= action_i;
      addr_q   <= bus_address_i;
      word_q   <= word_access_i;
      wbyte_q  <= write_value_i[ByteW-1:0];
      cycles_q <= elapsed_cycles_i;
    end
  end

  // Decode the device address
  assign is_dev = (addr_q == ADDR_SER_CTRL) || (addr_q == ADDR_SER_DATA) ||
                  (addr_q == ADDR_RLD_H)    || (addr_q == ADDR_RLD_M)    ||
                  (addr_q == ADDR_RLD_L)    || (addr_q == ADDR_TCTRL)    ||
                  (addr_q == ADDR_TSTAT);

  // Prescaler: drop by the elapsed cycles, then refill and tick the counter on underflow
  always_comb begin
    if (!pre_q[PreW-1] && ten_q) begin
      pre_sub = pre_q - $signed({{(PreW-CyclesW){1'b0}}, cycles_q});
    end else begin
      pre_sub = pre_q;
    end
    pre_neg = pre_sub[PreW-1];
    cnt_dec = pre_neg ? cnt_q - CountW'(1) : cnt_q;
  end

  // Apply one item to the state and form its result
  always_comb begin
    cnt_d   = cnt_q;
    rld_d   = rld_q;
    pre_d   = pre_q;
    ten_d   = ten_q;
    sen_d   = sen_q;
    irq_d   = irq_q;
    rdata_d = '0;
    hit_d   = 1'b0;
    fault_d = 1'b0;
    txv_d   = 1'b0;
    txb_d   = '0;
    case (action_q)
      ACT_TICK: begin
        pre_d = pre_neg ? pre_sub + PreDiv : pre_sub;
        if (cnt_dec == '0) begin
          cnt_d = rld_q;
          if (ten_q) begin
            irq_d = IRQ_TIMER;
          end
        end else begin
          cnt_d = cnt_dec;
        end
      end
      ACT_READ: begin
        if (is_dev) begin
          if (word_q) begin
            hit_d   = 1'b1;
            fault_d = 1'b1;
          end else if (addr_q == ADDR_SER_CTRL) begin
            hit_d   = 1'b1;
            rdata_d = SER_STATUS_RD;
          end else if (addr_q != ADDR_TSTAT) begin
            hit_d   = 1'b1;
            fault_d = 1'b1;
          end
        end
      end
      ACT_WRITE: begin
        if (is_dev) begin
          hit_d = 1'b1;
          if (word_q) begin
            fault_d = 1'b1;
          end else begin
            case (addr_q)
              ADDR_SER_CTRL: sen_d = (wbyte_q == SER_ENABLE_KEY);
              ADDR_SER_DATA: begin
                txv_d = 1'b1;
                txb_d = wbyte_q;
              end
              ADDR_RLD_H:    rld_d[23:16] = wbyte_q;
              ADDR_RLD_M:    rld_d[15:8]  = wbyte_q;
              ADDR_RLD_L:    rld_d[7:0]   = wbyte_q;
              ADDR_TCTRL:    ten_d = wbyte_q[TCTRL_EN_BIT];
              default: begin
                if (wbyte_q == TSTAT_CLEAR_KEY) begin
                  irq_d = IRQ_NONE;
                end
              end
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  // Advance the state when the item moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rld_q <= '0;
      pre_q <= '0;
      ten_q <= 1'b0;
      sen_q <= 1'b0;
      irq_q <= IRQ_NONE;
    end else if (fire) begin
      cnt_q <= cnt_d;
      rld_q <= rld_d;
      pre_q <= pre_d;
      ten_q <= ten_d;
      sen_q <= sen_d;
      irq_q <= irq_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rdata_q <= rdata_d;
      hit_q   <= hit_d;
      fault_q <= fault_d;
      txv_q   <= txv_d;
      txb_q   <= txb_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign read_data_o    = rdata_q;
  assign handled_here_o = hit_q;
  assign access_fault_o = fault_q;
  assign tx_valid_o     = txv_q;
  assign tx_byte_o      = txb_q;
  // Status fields show the state left by the last item taken into the result register
  assign irq_level_o    = irq_q;
  assign serial_on_o    = sen_q;
  assign timer_on_o     = ten_q;

endmodule

// ----- hdl/btstx_checker.sv -----
// Port-level checks for the board timer and serial transmit block, bound to its top level.
// Depends on btstx_pkg and board_timer_and_serial_tx_io_top_defines.svh.
`include "board_timer_and_serial_tx_io_top_defines.svh"

module btstx_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [btstx_pkg::ByteW-1:0]   read_data_o,
  input logic                          handled_here_o,
  input logic                          access_fault_o,
  input logic                          tx_valid_o,
  input logic [btstx_pkg::ByteW-1:0]   tx_byte_o,
  input logic [btstx_pkg::IrqW-1:0]    irq_level_o
);
  import btstx_pkg::*;

  // Reset empties the result register and drops the interrupt
  `BTSTX_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o && irq_level_o == IRQ_NONE)

  // A stalled result beat stays and keeps its data
  `BTSTX_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o) && $stable(tx_byte_o) && $stable(access_fault_o))

  // The interrupt level is only ever idle or the timer level
  `BTSTX_ASSERT(a_irq_code, irq_level_o == IRQ_NONE || irq_level_o == IRQ_TIMER)

  // A fault is always claimed by the device and sends nothing
  `BTSTX_ASSERT(a_fault_hit, out_valid_o && access_fault_o |-> handled_here_o && !tx_valid_o && read_data_o == '0)

  // Read data only comes from the serial status register
  `BTSTX_ASSERT(a_rdata, out_valid_o && read_data_o != '0 |-> handled_here_o && !access_fault_o && !tx_valid_o && read_data_o == SER_STATUS_RD)

endmodule

bind board_timer_and_serial_tx_io_top btstx_checker u_btstx_checker (.*);
